// ===== design/gds_pkg.sv =====
// ----------------------------------------------------------------------------
// gds_pkg
// Shared types, constants and calendar functions for the date subtractor.
// ----------------------------------------------------------------------------
package gds_pkg;

	localparam int OpW   = 3;
	localparam int AmtW  = 12;
	localparam int DayW  = 5;
	localparam int MonW  = 4;
	localparam int YearW = 14;

	localparam logic [MonW-1:0]  MONTH_JAN = 4'd1;
	localparam logic [MonW-1:0]  MONTH_FEB = 4'd2;
	localparam logic [MonW-1:0]  MONTH_DEC = 4'd12;
	localparam logic [DayW-1:0]  DAY_FIRST = 5'd1;
	localparam logic [DayW-1:0]  LEAP_FEB_LEN = 5'd29;
	localparam logic [DayW-1:0]  LONG_MONTH_LEN = 5'd31;
	localparam logic [YearW-1:0] YEAR_FIRST = 14'd1;

	// floor(y / 25) = (y * RECIP25) >> 17 for every 14-bit year
	localparam logic [27:0] RECIP25 = 28'd5243;

	localparam logic [DayW-1:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef enum logic [OpW-1:0] {
		OP_DAYS      = 3'd0,
		OP_WEEKS     = 3'd1,
		OP_MONTHS    = 3'd2,
		OP_YEARS     = 3'd3,
		OP_DECADES   = 3'd4,
		OP_CENTURIES = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_DAYS,
		ST_MONTHS,
		ST_YMUL,
		ST_YSUB,
		ST_YCLAMP,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic step_day;
		logic step_month;
		logic mul;
		logic ysub;
		logic yclamp;
		logic emit;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic echo;
		logic walk_done;
		logic out_free;
	} stat_t;

	function automatic logic is_leap(input logic [YearW-1:0] y);
		logic [27:0] prod;
		logic [10:0] q;
		logic [14:0] q25;
		logic        div4;
		logic        div16;
		logic        div25;
		begin
			prod  = 28'(y) * RECIP25;
			q     = prod[27:17];
			q25   = {q, 4'b0000} + {1'b0, q, 3'b000} + {4'b0000, q};
			div25 = (q25 == 15'(y));
			div4  = (y[1:0] == 2'b00);
			div16 = (y[3:0] == 4'b0000);
			is_leap = div4 && (!div25 || div16);
		end
	endfunction

	function automatic logic [DayW-1:0] days_in_month(input logic [MonW-1:0] m,
		input logic [YearW-1:0] y);
		begin
			if (m == MONTH_FEB && is_leap(y)) begin
				days_in_month = LEAP_FEB_LEN;
			end else if (m < MONTH_JAN || m > MONTH_DEC) begin
				days_in_month = LONG_MONTH_LEN;
			end else begin
				days_in_month = MONTH_LEN[m - MONTH_JAN];
			end
		end
	endfunction

endpackage

// ===== design/gregorian_date_subtract.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_subtract
// Moves a Gregorian date back by a count of days, weeks, months, years,
// decades or centuries, one request at a time. A request is loaded and
// sorted by operation, worked, then handed over. Year, decade and century
// steps multiply, subtract and clamp the day; month steps go back one month
// per step; day and week steps walk the calendar a month at a time, a step
// toward the first of the month and a step across into the month before. A
// walk that runs past year 1 stops early. A new request is taken once the
// previous result sits in the output register, even if that result has not
// been collected. A result before year 1 echoes the input date with the
// underflow flag set; an unknown operation echoes it without the flag.
// ----------------------------------------------------------------------------
module gregorian_date_subtract #(
	parameter int COUNT_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // amount, in_day, in_month, in_year
	input  logic [2:0]  s_axis_tuser,   // operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // out_day, out_month, out_year
	output logic [0:0]  m_axis_tuser    // underflow
);

	gds_pkg::cmd_t                cmd;
	gds_pkg::stat_t               st;
	logic [gds_pkg::DayW-1:0]     out_day;
	logic [gds_pkg::MonW-1:0]     out_month;
	logic [gds_pkg::YearW-1:0]    out_year;
	logic                         out_under;

	gds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	gds_dp #(
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_op     (s_axis_tuser),
		.in_amount (s_axis_tdata[11:0]),
		.in_day    (s_axis_tdata[16:12]),
		.in_month  (s_axis_tdata[20:17]),
		.in_year   (s_axis_tdata[34:21]),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_day   (out_day),
		.out_month (out_month),
		.out_year  (out_year),
		.out_under (out_under)
	);

	assign m_axis_tdata = {1'b0, out_year, out_month, out_day};
	assign m_axis_tuser = out_under;

endmodule

// ===== design/gds_dp.sv =====
// ----------------------------------------------------------------------------
// gds_dp
// Date datapath: input capture and correction, day and month walking, year
// multiply and subtract, and the output register.
// ----------------------------------------------------------------------------
module gds_dp #(
	parameter int COUNT_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gds_pkg::cmd_t                cmd,
	output gds_pkg::stat_t               st,
	input  logic [gds_pkg::OpW-1:0]      in_op,
	input  logic [gds_pkg::AmtW-1:0]     in_amount,
	input  logic [gds_pkg::DayW-1:0]     in_day,
	input  logic [gds_pkg::MonW-1:0]     in_month,
	input  logic [gds_pkg::YearW-1:0]    in_year,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [gds_pkg::DayW-1:0]     out_day,
	output logic [gds_pkg::MonW-1:0]     out_month,
	output logic [gds_pkg::YearW-1:0]    out_year,
	output logic                         out_under
);

	localparam int CntW = (COUNT_BITS < gds_pkg::AmtW) ? COUNT_BITS : gds_pkg::AmtW;
	localparam int RemW = CntW + 3;
	localparam int PrdW = CntW + 7;
	localparam int CmpW = (PrdW > gds_pkg::YearW) ? PrdW : gds_pkg::YearW;

	gds_pkg::op_t                 op_q;
	logic                         echo_q;
	logic                         under_q;
	logic [RemW-1:0]              rem_q;
	logic [PrdW-1:0]              prod_q;
	logic [gds_pkg::DayW-1:0]     day_q;
	logic [gds_pkg::MonW-1:0]     mon_q;
	logic [gds_pkg::YearW-1:0]    yr_q;
	logic [gds_pkg::DayW-1:0]     raw_day_q;
	logic [gds_pkg::MonW-1:0]     raw_mon_q;
	logic [gds_pkg::YearW-1:0]    raw_yr_q;
	logic                         out_valid_q;
	logic [gds_pkg::DayW-1:0]     out_day_q;
	logic [gds_pkg::MonW-1:0]     out_mon_q;
	logic [gds_pkg::YearW-1:0]    out_yr_q;
	logic                         out_under_q;

	logic [CntW-1:0]              amt_c;
	logic                         op_known;
	logic [gds_pkg::MonW-1:0]     mon_c;
	logic [gds_pkg::DayW-1:0]     dim_in;
	logic [gds_pkg::DayW-1:0]     day_c;
	logic [RemW-1:0]              rem_c;
	logic [gds_pkg::MonW-1:0]     mon_dec;
	logic [gds_pkg::YearW-1:0]    yr_dec;
	logic [gds_pkg::DayW-1:0]     dim_prev;
	logic [gds_pkg::DayW-1:0]     dim_cur;
	logic [gds_pkg::DayW-1:0]     dm1;
	logic [6:0]                   unit_c;

	always_comb begin
		amt_c    = in_amount[CntW-1:0];
		op_known = (in_op <= gds_pkg::OpW'(gds_pkg::OP_CENTURIES));
		if (in_month < gds_pkg::MONTH_JAN) begin
			mon_c = gds_pkg::MONTH_JAN;
		end else if (in_month > gds_pkg::MONTH_DEC) begin
			mon_c = gds_pkg::MONTH_DEC;
		end else begin
			mon_c = in_month;
		end
		dim_in = gds_pkg::days_in_month(mon_c, in_year);
		if (in_day < gds_pkg::DAY_FIRST) begin
			day_c = gds_pkg::DAY_FIRST;
		end else if (in_day > dim_in) begin
			day_c = dim_in;
		end else begin
			day_c = in_day;
		end
		if (in_op == gds_pkg::OpW'(gds_pkg::OP_WEEKS)) begin
			rem_c = {amt_c, 3'b000} - RemW'(amt_c);
		end else begin
			rem_c = RemW'(amt_c);
		end
		mon_dec  = mon_q - gds_pkg::MONTH_JAN;
		yr_dec   = yr_q - gds_pkg::YEAR_FIRST;
		dim_prev = gds_pkg::days_in_month(mon_dec, yr_q);
		dim_cur  = gds_pkg::days_in_month(mon_q, yr_q);
		dm1      = day_q - gds_pkg::DAY_FIRST;
		case (op_q)
			gds_pkg::OP_YEARS:   unit_c = 7'd1;
			gds_pkg::OP_DECADES: unit_c = 7'd10;
			default:             unit_c = 7'd100;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_q  <= 1'b0;
			under_q <= 1'b0;
		end else if (cmd.load) begin
			echo_q  <= !op_known;
			under_q <= op_known && (in_year == '0);
		end else if (cmd.step_day || cmd.step_month) begin
			if (mon_q == gds_pkg::MONTH_JAN && yr_q == gds_pkg::YEAR_FIRST &&
				(cmd.step_month || day_q == gds_pkg::DAY_FIRST)) begin
				under_q <= 1'b1;
			end
		end else if (cmd.ysub) begin
			if (CmpW'(prod_q) >= CmpW'(yr_q)) begin
				under_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= gds_pkg::op_t'(in_op);
			rem_q     <= rem_c;
			day_q     <= day_c;
			mon_q     <= mon_c;
			yr_q      <= in_year;
			raw_day_q <= in_day;
			raw_mon_q <= in_month;
			raw_yr_q  <= in_year;
		end else if (cmd.step_day && !under_q) begin
			if (day_q > gds_pkg::DAY_FIRST) begin
				if (rem_q >= RemW'(dm1)) begin
					rem_q <= rem_q - RemW'(dm1);
					day_q <= gds_pkg::DAY_FIRST;
				end else begin
					rem_q <= '0;
					day_q <= day_q - gds_pkg::DayW'(rem_q);
				end
			end else if (mon_q == gds_pkg::MONTH_JAN) begin
				if (yr_q != gds_pkg::YEAR_FIRST) begin
					rem_q <= rem_q - RemW'(1);
					mon_q <= gds_pkg::MONTH_DEC;
					yr_q  <= yr_dec;
					day_q <= gds_pkg::LONG_MONTH_LEN;
				end
			end else begin
				rem_q <= rem_q - RemW'(1);
				mon_q <= mon_dec;
				day_q <= dim_prev;
			end
		end else if (cmd.step_month && !under_q) begin
			if (mon_q == gds_pkg::MONTH_JAN) begin
				if (yr_q != gds_pkg::YEAR_FIRST) begin
					rem_q <= rem_q - RemW'(1);
					mon_q <= gds_pkg::MONTH_DEC;
					yr_q  <= yr_dec;
				end
			end else begin
				rem_q <= rem_q - RemW'(1);
				mon_q <= mon_dec;
				if (day_q > dim_prev) begin
					day_q <= dim_prev;
				end
			end
		end else if (cmd.mul) begin
			prod_q <= PrdW'(rem_q[CntW-1:0]) * PrdW'(unit_c);
		end else if (cmd.ysub) begin
			if (CmpW'(prod_q) < CmpW'(yr_q)) begin
				yr_q <= yr_q - gds_pkg::YearW'(prod_q);
			end
		end else if (cmd.yclamp) begin
			if (day_q > dim_cur) begin
				day_q <= dim_cur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (echo_q || under_q) begin
				out_day_q <= raw_day_q;
				out_mon_q <= raw_mon_q;
				out_yr_q  <= raw_yr_q;
			end else begin
				out_day_q <= day_q;
				out_mon_q <= mon_q;
				out_yr_q  <= yr_q;
			end
			out_under_q <= under_q;
		end
	end

	always_comb begin
		st.op        = op_q;
		st.echo      = echo_q || under_q;
		st.walk_done = under_q || (rem_q == '0);
		st.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_day   = out_day_q;
	assign out_month = out_mon_q;
	assign out_year  = out_yr_q;
	assign out_under = out_under_q;

	a_load_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (mon_q >= gds_pkg::MONTH_JAN && mon_q <= gds_pkg::MONTH_DEC &&
		day_q >= gds_pkg::DAY_FIRST))
		else $error("corrected date out of range after load");

	a_day_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step_day && !under_q && rem_q != '0) |=> (under_q || rem_q < $past(rem_q)))
		else $error("day walk made no progress");

	a_month_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step_month && !under_q && rem_q != '0) |=>
		(under_q || rem_q == $past(rem_q) - RemW'(1)))
		else $error("month walk did not advance by one");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("result not held in output register");

endmodule

// ===== design/gds_ctrl.sv =====
// ----------------------------------------------------------------------------
// gds_ctrl
// Sequencer: accepts a request, steers the datapath through the walk or the
// year subtraction and hands the result to the output register.
// ----------------------------------------------------------------------------
module gds_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  gds_pkg::stat_t  st,
	output gds_pkg::cmd_t   cmd
);

	gds_pkg::state_t state_q;
	gds_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gds_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			gds_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = gds_pkg::ST_START;
				end
			end
			gds_pkg::ST_START: begin
				if (st.echo) begin
					state_d = gds_pkg::ST_FINISH;
				end else begin
					case (st.op)
						gds_pkg::OP_DAYS:   state_d = gds_pkg::ST_DAYS;
						gds_pkg::OP_WEEKS:  state_d = gds_pkg::ST_DAYS;
						gds_pkg::OP_MONTHS: state_d = gds_pkg::ST_MONTHS;
						default:            state_d = gds_pkg::ST_YMUL;
					endcase
				end
			end
			gds_pkg::ST_DAYS: begin
				if (st.walk_done) begin
					state_d = gds_pkg::ST_FINISH;
				end else begin
					cmd.step_day = 1'b1;
				end
			end
			gds_pkg::ST_MONTHS: begin
				if (st.walk_done) begin
					state_d = gds_pkg::ST_FINISH;
				end else begin
					cmd.step_month = 1'b1;
				end
			end
			gds_pkg::ST_YMUL: begin
				cmd.mul = 1'b1;
				state_d = gds_pkg::ST_YSUB;
			end
			gds_pkg::ST_YSUB: begin
				cmd.ysub = 1'b1;
				state_d  = gds_pkg::ST_YCLAMP;
			end
			gds_pkg::ST_YCLAMP: begin
				cmd.yclamp = 1'b1;
				state_d    = gds_pkg::ST_FINISH;
			end
			gds_pkg::ST_FINISH: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = gds_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gds_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
